### rtl/core/pbs_pkg.sv
// Shared types, constants and helper functions of the power button sequencer.
`default_nettype none

package pbs_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned MvWidth   = 16;
  localparam int unsigned MsWidth   = 16;
  localparam int unsigned TickWidth = 10;
  localparam int unsigned PctWidth  = 7;
  localparam int unsigned PatWidth  = 4;
  // Quotient never exceeds 100, so seven quotient bits cover it.
  localparam int unsigned NumWidth  = MvWidth + PctWidth;
  localparam int unsigned BitIdxWidth = 3;

  localparam logic [MsWidth-1:0]   MS_SAT      = '1;
  localparam logic [PctWidth-1:0]  PCT_FULL    = 7'd100;
  localparam logic [BitIdxWidth-1:0] DIV_TOP_BIT = 3'd6;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd1;
  localparam logic [2:0] REG_TICK         = 3'd2;
  localparam logic [2:0] REG_EMPTY        = 3'd3;
  localparam logic [2:0] REG_FULL         = 3'd4;

  localparam logic [MsWidth-1:0]   RST_IDLE_TIMEOUT = 16'd3000;
  localparam logic [MsWidth-1:0]   RST_LONG_PRESS   = 16'd1000;
  localparam logic [TickWidth-1:0] RST_TICK         = 10'd100;
  localparam logic [MvWidth-1:0]   RST_EMPTY        = 16'd18000;
  localparam logic [MvWidth-1:0]   RST_FULL         = 16'd25200;

  // LED pattern codes.
  localparam logic [PatWidth-1:0] PAT_STARTUP  = 4'd0;
  localparam logic [PatWidth-1:0] PAT_CONFIRM  = 4'd1;
  localparam logic [PatWidth-1:0] PAT_SHUTDOWN = 4'd2;
  localparam logic [PatWidth-1:0] PAT_LEVEL_7  = 4'd3;
  localparam logic [PatWidth-1:0] PAT_LEVEL_6  = 4'd4;
  localparam logic [PatWidth-1:0] PAT_LEVEL_5  = 4'd5;
  localparam logic [PatWidth-1:0] PAT_LEVEL_4  = 4'd6;
  localparam logic [PatWidth-1:0] PAT_LEVEL_3  = 4'd7;
  localparam logic [PatWidth-1:0] PAT_LEVEL_2  = 4'd8;
  localparam logic [PatWidth-1:0] PAT_LEVEL_1  = 4'd9;
  localparam logic [PatWidth-1:0] PAT_LEVEL_0  = 4'd10;
  localparam logic [PatWidth-1:0] PAT_DARK     = 4'd11;

  typedef struct packed {
    logic [MsWidth-1:0]   idle_timeout_ms;
    logic [MsWidth-1:0]   long_press_ms;
    logic [TickWidth-1:0] tick_ms;
    logic [MvWidth-1:0]   empty_mv;
    logic [MvWidth-1:0]   full_mv;
  } cfg_t;

  typedef enum logic [1:0] {
    IDLE_ADV,
    IDLE_CLR,
    IDLE_SAT
  } idle_op_t;

  typedef enum logic [2:0] {
    PSEL_KEEP,
    PSEL_STARTUP,
    PSEL_CONFIRM,
    PSEL_SHUTDOWN,
    PSEL_LEVEL,
    PSEL_DARK
  } pat_op_t;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    logic     div_step;
    logic     commit;
    idle_op_t idle_op;
    logic     press_clr;
    pat_op_t  pat_op;
    logic     power_on;
    logic     asleep;
  } cmd_t;

  typedef struct packed {
    logic pressed;
    logic idle_passed;
    logic press_passed;
    logic div_last;
    logic out_busy;
  } status_t;

  // Eight charge bands, fullest first.
  function automatic logic [PatWidth-1:0] level_pattern(input logic [PctWidth-1:0] pct);
    logic [PatWidth-1:0] pat;
    if (pct > 7'd87)      pat = PAT_LEVEL_7;
    else if (pct > 7'd75) pat = PAT_LEVEL_6;
    else if (pct > 7'd62) pat = PAT_LEVEL_5;
    else if (pct > 7'd50) pat = PAT_LEVEL_4;
    else if (pct > 7'd37) pat = PAT_LEVEL_3;
    else if (pct > 7'd25) pat = PAT_LEVEL_2;
    else if (pct > 7'd12) pat = PAT_LEVEL_1;
    else                  pat = PAT_LEVEL_0;
    return pat;
  endfunction

  // Add a tick to an elapsed counter, holding at full scale.
  function automatic logic [MsWidth-1:0] sat_add(input logic [MsWidth-1:0] a,
                                                 input logic [TickWidth-1:0] b);
    logic [MsWidth:0] s;
    s = {1'b0, a} + {{(MsWidth+1-TickWidth){1'b0}}, b};
    return s[MsWidth] ? MS_SAT : s[MsWidth-1:0];
  endfunction

  // A saturated counter is past any limit.
  function automatic logic passed(input logic [MsWidth-1:0] elapsed,
                                  input logic [MsWidth-1:0] limit);
    return (elapsed == MS_SAT) || (elapsed > limit);
  endfunction

endpackage

`default_nettype wire

### rtl/core/pbs_regs.sv
// APB-style configuration register file of the power button sequencer.
`default_nettype none

module pbs_regs
  import pbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[AddrWidth-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_IDLE_TIMEOUT: cfg_nxt.idle_timeout_ms = pwdata[MsWidth-1:0];
        REG_LONG_PRESS:   cfg_nxt.long_press_ms   = pwdata[MsWidth-1:0];
        REG_TICK:         cfg_nxt.tick_ms         = pwdata[TickWidth-1:0];
        REG_EMPTY:        cfg_nxt.empty_mv        = pwdata[MvWidth-1:0];
        REG_FULL:         cfg_nxt.full_mv         = pwdata[MvWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IDLE_TIMEOUT: prdata = {{(DataWidth-MsWidth){1'b0}}, cfg_r.idle_timeout_ms};
      REG_LONG_PRESS:   prdata = {{(DataWidth-MsWidth){1'b0}}, cfg_r.long_press_ms};
      REG_TICK:         prdata = {{(DataWidth-TickWidth){1'b0}}, cfg_r.tick_ms};
      REG_EMPTY:        prdata = {{(DataWidth-MvWidth){1'b0}}, cfg_r.empty_mv};
      REG_FULL:         prdata = {{(DataWidth-MvWidth){1'b0}}, cfg_r.full_mv};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_timeout_ms <= RST_IDLE_TIMEOUT;
      cfg_r.long_press_ms   <= RST_LONG_PRESS;
      cfg_r.tick_ms         <= RST_TICK;
      cfg_r.empty_mv        <= RST_EMPTY;
      cfg_r.full_mv         <= RST_FULL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/pbs_datapath.sv
// Datapath: input capture, percentage divider, elapsed counters, pattern and result register.
`default_nettype none

module pbs_datapath
  import pbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic               in_button_pressed,
  input  wire logic [MvWidth-1:0] in_voltage_mv,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_power_enable,
  output logic [PatWidth-1:0]     out_pattern_code,
  output logic [PctWidth-1:0]     out_battery_percent,
  output logic                    out_asleep
);

  logic                   pressed_r;
  logic [MvWidth-1:0]     mv_r;
  logic [MvWidth-1:0]     span_r;
  logic [NumWidth-1:0]    rem_r, rem_nxt;
  logic [PctWidth-1:0]    quo_r, quo_nxt;
  logic [BitIdxWidth-1:0] bit_r, bit_nxt;
  logic                   div_en_r, div_en_nxt;
  logic [MsWidth-1:0]     idle_r, idle_nxt;
  logic [MsWidth-1:0]     press_r, press_nxt;
  logic [PatWidth-1:0]    pattern_r, pattern_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_power_r;
  logic [PatWidth-1:0]    out_pattern_r;
  logic [PctWidth-1:0]    out_pct_r;
  logic                   out_asleep_r;

  logic [MsWidth-1:0]     idle_adv;
  logic [MsWidth-1:0]     press_adv;
  logic                   below, above, zero_span;
  logic [MvWidth-1:0]     span;
  logic [MvWidth-1:0]     diff;
  logic [NumWidth-1:0]    numer;
  logic [NumWidth-1:0]    divisor;

  assign idle_adv  = sat_add(idle_r, cfg.tick_ms);
  assign press_adv = sat_add(press_r, cfg.tick_ms);

  assign below     = mv_r < cfg.empty_mv;
  assign above     = mv_r > cfg.full_mv;
  assign span      = cfg.full_mv - cfg.empty_mv;
  assign zero_span = (span == '0);
  assign diff      = mv_r - cfg.empty_mv;
  // diff * 100 as 64 + 32 + 4.
  assign numer = {1'b0, diff, 6'b0} + {2'b0, diff, 5'b0} + {5'b0, diff, 2'b0};
  assign divisor = {{(NumWidth-MvWidth){1'b0}}, span_r} << bit_r;

  assign status.pressed      = pressed_r;
  assign status.idle_passed  = passed(idle_adv, cfg.idle_timeout_ms);
  assign status.press_passed = passed(press_adv, cfg.long_press_ms);
  assign status.div_last     = (bit_r == '0);
  assign status.out_busy     = out_valid_r & out_stall;

  // Restoring divider: one quotient bit per step, top bit first.
  always_comb begin
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    bit_nxt    = bit_r;
    div_en_nxt = div_en_r;
    if (cmd.div_start) begin
      rem_nxt    = numer;
      bit_nxt    = DIV_TOP_BIT;
      div_en_nxt = !(below || above || zero_span);
      quo_nxt    = below ? '0 : ((above || zero_span) ? PCT_FULL : '0);
    end else if (cmd.div_step) begin
      if (div_en_r && (rem_r >= divisor)) begin
        rem_nxt        = rem_r - divisor;
        quo_nxt[bit_r] = 1'b1;
      end
      if (bit_r != '0) begin
        bit_nxt = bit_r - 1'b1;
      end
    end
  end

  always_comb begin
    idle_nxt    = idle_r;
    press_nxt   = press_r;
    pattern_nxt = pattern_r;
    if (cmd.commit) begin
      case (cmd.idle_op)
        IDLE_CLR: idle_nxt = '0;
        IDLE_SAT: idle_nxt = MS_SAT;
        default:  idle_nxt = idle_adv;
      endcase
      press_nxt = cmd.press_clr ? '0 : press_adv;
      case (cmd.pat_op)
        PSEL_STARTUP:  pattern_nxt = PAT_STARTUP;
        PSEL_CONFIRM:  pattern_nxt = PAT_CONFIRM;
        PSEL_SHUTDOWN: pattern_nxt = PAT_SHUTDOWN;
        PSEL_LEVEL:    pattern_nxt = level_pattern(quo_r);
        PSEL_DARK:     pattern_nxt = PAT_DARK;
        default:       pattern_nxt = pattern_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r      <= '0;
      press_r     <= '0;
      pattern_r   <= PAT_DARK;
      out_valid_r <= 1'b0;
    end else begin
      idle_r      <= idle_nxt;
      press_r     <= press_nxt;
      pattern_r   <= pattern_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pressed_r <= in_button_pressed;
      mv_r      <= in_voltage_mv;
    end
    if (cmd.div_start) begin
      span_r <= span;
    end
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    bit_r    <= bit_nxt;
    div_en_r <= div_en_nxt;
    if (cmd.commit) begin
      out_power_r   <= cmd.power_on;
      out_pattern_r <= pattern_nxt;
      out_pct_r     <= quo_r;
      out_asleep_r  <= cmd.asleep;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_power_enable    = out_power_r;
  assign out_pattern_code    = out_pattern_r;
  assign out_battery_percent = out_pct_r;
  assign out_asleep          = out_asleep_r;

endmodule

`default_nettype wire

### rtl/core/pbs_ctrl.sv
// Controller: item sequencing and the power phase state machine.
`default_nettype none

module pbs_ctrl
  import pbs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [3:0] {
    SEQ_IDLE = 4'b0001,
    SEQ_MUL  = 4'b0010,
    SEQ_DIV  = 4'b0100,
    SEQ_DONE = 4'b1000
  } seq_t;

  typedef enum logic [6:0] {
    PH_WAKE_WAIT    = 7'b0000001,
    PH_OFF_IDLE     = 7'b0000010,
    PH_ON_WAIT      = 7'b0000100,
    PH_RUN          = 7'b0001000,
    PH_CONFIRM_WAIT = 7'b0010000,
    PH_OFF_WAIT     = 7'b0100000,
    PH_SLEEP        = 7'b1000000
  } phase_t;

  seq_t     seq_r, seq_nxt;
  phase_t   phase_r, phase_nxt;
  logic     press_started_r, press_started_nxt;
  logic     power_on_r, power_on_nxt;
  logic     commit;
  idle_op_t idle_op;
  logic     press_clr;
  pat_op_t  pat_op;

  assign in_stall = (seq_r != SEQ_IDLE);
  assign commit   = (seq_r == SEQ_DONE) && !status.out_busy;

  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      SEQ_IDLE: if (in_valid) seq_nxt = SEQ_MUL;
      SEQ_MUL:  seq_nxt = SEQ_DIV;
      SEQ_DIV:  if (status.div_last) seq_nxt = SEQ_DONE;
      SEQ_DONE: if (!status.out_busy) seq_nxt = SEQ_IDLE;
      default:  seq_nxt = SEQ_IDLE;
    endcase
  end

  // One poll tick of the power logic, evaluated on the advanced counters.
  always_comb begin
    phase_nxt         = phase_r;
    press_started_nxt = press_started_r;
    power_on_nxt      = power_on_r;
    idle_op           = IDLE_ADV;
    press_clr         = 1'b0;
    pat_op            = PSEL_KEEP;
    unique case (phase_r)
      PH_WAKE_WAIT: begin
        // On release the idle counter restarts, so the timeout cannot fire.
        if (!status.pressed) begin
          idle_op           = IDLE_CLR;
          phase_nxt         = PH_OFF_IDLE;
          pat_op            = PSEL_LEVEL;
          press_started_nxt = 1'b0;
        end
      end
      PH_OFF_IDLE: begin
        if (status.idle_passed) begin
          phase_nxt = PH_SLEEP;
          pat_op    = PSEL_DARK;
        end else if (status.pressed) begin
          idle_op = IDLE_CLR;
          if (!press_started_r) begin
            pat_op            = PSEL_STARTUP;
            press_clr         = 1'b1;
            press_started_nxt = 1'b1;
          end else if (status.press_passed) begin
            phase_nxt = PH_ON_WAIT;
          end
        end else begin
          pat_op            = PSEL_LEVEL;
          press_started_nxt = 1'b0;
        end
      end
      PH_ON_WAIT: begin
        // The idle counter is forced to expired, so the level shows at once.
        if (!status.pressed) begin
          power_on_nxt      = 1'b1;
          idle_op           = IDLE_SAT;
          press_started_nxt = 1'b0;
          phase_nxt         = PH_RUN;
          pat_op            = PSEL_LEVEL;
        end
      end
      PH_RUN: begin
        if (status.pressed) begin
          idle_op = IDLE_CLR;
          if (status.idle_passed) begin
            pat_op    = PSEL_CONFIRM;
            phase_nxt = PH_CONFIRM_WAIT;
          end else if (!press_started_r) begin
            pat_op            = PSEL_SHUTDOWN;
            press_clr         = 1'b1;
            press_started_nxt = 1'b1;
          end else if (status.press_passed) begin
            phase_nxt = PH_OFF_WAIT;
          end
        end else begin
          pat_op            = status.idle_passed ? PSEL_LEVEL : PSEL_CONFIRM;
          press_started_nxt = 1'b0;
        end
      end
      PH_CONFIRM_WAIT: begin
        if (!status.pressed) begin
          phase_nxt         = PH_RUN;
          pat_op            = status.idle_passed ? PSEL_LEVEL : PSEL_CONFIRM;
          press_started_nxt = 1'b0;
        end
      end
      PH_OFF_WAIT: begin
        if (!status.pressed) begin
          power_on_nxt = 1'b0;
          phase_nxt    = PH_SLEEP;
          pat_op       = PSEL_DARK;
        end
      end
      PH_SLEEP: begin
        if (status.pressed) begin
          phase_nxt = PH_WAKE_WAIT;
        end else begin
          pat_op = PSEL_DARK;
        end
      end
      default: begin
        phase_nxt = PH_SLEEP;
        pat_op    = PSEL_DARK;
      end
    endcase
  end

  always_comb begin
    cmd.capture   = (seq_r == SEQ_IDLE) && in_valid;
    cmd.div_start = (seq_r == SEQ_MUL);
    cmd.div_step  = (seq_r == SEQ_DIV);
    cmd.commit    = commit;
    cmd.idle_op   = idle_op;
    cmd.press_clr = press_clr;
    cmd.pat_op    = pat_op;
    cmd.power_on  = power_on_nxt;
    cmd.asleep    = (phase_nxt == PH_SLEEP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r           <= SEQ_IDLE;
      phase_r         <= PH_WAKE_WAIT;
      press_started_r <= 1'b0;
      power_on_r      <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      if (commit) begin
        phase_r         <= phase_nxt;
        press_started_r <= press_started_nxt;
        power_on_r      <= power_on_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/power_button_sequencer.sv
// Power button sequencer top level: register file, controller and datapath.
//
// Each input beat is one poll tick; each tick yields exactly one result beat.
// An accepted tick is handled in order: capture of the beat, scaling of the
// voltage offset by 100, the restoring divider that forms the seven bits of
// the battery percentage, and an update of the power phase, counters and
// LED pattern that also loads the result register. in_stall is high from the
// cycle after acceptance until that update, so a new tick is not taken until
// the last is through; a result held by out_stall delays the update until the
// result register frees. Registers lie at byte addresses 0, 4, 8, 12 and 16 in
// the order idle timeout, long press, tick length, empty and full voltage.
`default_nettype none

module power_button_sequencer
  import pbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_button_pressed,
  input  wire logic [MvWidth-1:0]   in_voltage_mv,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_power_enable,
  output logic [PatWidth-1:0]       out_pattern_code,
  output logic [PctWidth-1:0]       out_battery_percent,
  output logic                      out_asleep,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  pbs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pbs_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .status              (status),
    .in_button_pressed   (in_button_pressed),
    .in_voltage_mv       (in_voltage_mv),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_power_enable    (out_power_enable),
    .out_pattern_code    (out_pattern_code),
    .out_battery_percent (out_battery_percent),
    .out_asleep          (out_asleep)
  );

endmodule

`default_nettype wire

### rtl/core/pbs_checker.sv
// Port-level checker of the power button sequencer and its bind statement.
`default_nettype none

module pbs_checker
  import pbs_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic                out_power_enable,
  input wire logic [PatWidth-1:0] out_pattern_code,
  input wire logic [PctWidth-1:0] out_battery_percent,
  input wire logic                out_asleep
);

  // Reset leaves no result pending and the input open.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  // A tick is worked on alone: the input closes straight after a beat.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input still open the cycle after an accepted beat");

  // A sleeping block has the load off and the LED dark.
  a_sleep_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_asleep |-> !out_power_enable && out_pattern_code == PAT_DARK)
    else $error("asleep with power on or LED lit");

  a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_battery_percent <= PCT_FULL)
    else $error("battery percentage above full");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pattern_code)
      && $stable(out_battery_percent) && $stable(out_power_enable))
    else $error("stalled result changed");

endmodule

bind power_button_sequencer pbs_checker u_pbs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_power_enable    (out_power_enable),
  .out_pattern_code    (out_pattern_code),
  .out_battery_percent (out_battery_percent),
  .out_asleep          (out_asleep)
);

`default_nettype wire
